/* rtl/core/vist_pkg.sv */
// Package for the vector issue scoreboard timer.
// Time type, field widths, sequencer state codes. No dependencies.
package vist_pkg;

  localparam int unsigned TimeW  = 48;
  localparam int unsigned UnitW  = 3;
  localparam int unsigned RegW   = 6;
  localparam int unsigned LatW   = 16;

  typedef logic [TimeW-1:0] time_t;

  localparam time_t TimeMax = {TimeW{1'b1}};

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_MAX  = 7'b0000100,
    S_FIN  = 7'b0001000,
    S_BASE = 7'b0010000,
    S_DIF  = 7'b0100000,
    S_SUM  = 7'b1000000
  } state_e;

endpackage

/* rtl/core/vist_if.sv */
// Valid/ready channels for issue requests and timing results.
// Depends on vist_pkg.
interface vist_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [vist_pkg::UnitW-1:0]   unit_index;
  logic signed [vist_pkg::RegW-1:0]    dest_reg;
  logic signed [vist_pkg::RegW-1:0]    src_a_reg;
  logic signed [vist_pkg::RegW-1:0]    src_b_reg;
  logic        [vist_pkg::LatW-1:0]    op_latency;
  vist_pkg::time_t                     issue_time;

  modport source (output valid, unit_index, dest_reg, src_a_reg, src_b_reg, op_latency,
                  issue_time, input ready);
  modport sink   (input valid, unit_index, dest_reg, src_a_reg, src_b_reg, op_latency,
                  issue_time, output ready);
endinterface

interface vist_out_if;
  logic            valid;
  logic            ready;
  vist_pkg::time_t stall_delay;
  vist_pkg::time_t start_time;
  vist_pkg::time_t finish_time;
  vist_pkg::time_t total_runtime;

  modport source (output valid, stall_delay, start_time, finish_time, total_runtime,
                  input ready);
  modport sink   (input valid, stall_delay, start_time, finish_time, total_runtime,
                  output ready);
endinterface

/* rtl/core/vector_issue_scoreboard_timer_top.sv */
// Vector issue scoreboard timer: start/finish times and busy runtime per issue.
// Each transfer runs the read-max-add-accumulate sequence around the register
// ready-time RAMs; a new input is accepted only when idle, after write-back.
// A waiting result stalls only the final write-back step.
// Reset: asynchronous, active low; clears ready-time valid bits, unit times and totals.
// Depends on vist_pkg, vist_if, vist_ram.
module vector_issue_scoreboard_timer_top #(
  parameter int unsigned NUM_VREGS = 32,
  parameter int unsigned NUM_UNITS = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  vist_in_if.sink   in_i,
  vist_out_if.source out_o
);

  localparam int unsigned RegAw  = $clog2(NUM_VREGS);
  localparam int unsigned UnitAw = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;

  vist_pkg::state_e state_q, state_d;

  logic [vist_pkg::UnitW-1:0] unit_q;
  logic [vist_pkg::RegW-1:0]  dst_q, sa_q, sb_q;
  logic                       unit_ok_q, dst_ok_q, sa_ok_q, sb_ok_q;
  logic [vist_pkg::LatW-1:0]  lat_q;
  vist_pkg::time_t            issue_q, m1_q, m2_q, start_q, finish_q, base_q, add_q;
  logic                       none_q;

  vist_pkg::time_t unit_rt_q [NUM_UNITS];
  logic [NUM_VREGS-1:0] reg_vld_q;
  vist_pkg::time_t last_q, busy_q;

  logic            out_valid_q;
  vist_pkg::time_t out_stall_q, out_start_q, out_finish_q, out_total_q;

  logic            accept, fire;
  vist_pkg::time_t rd_a, rd_b, ram_a, ram_b, unit_rt;
  logic [vist_pkg::TimeW:0] fin_sum, busy_sum;

  function automatic logic idx_ok(logic [vist_pkg::RegW-1:0] f, int unsigned lim);
    return !f[vist_pkg::RegW-1] && (8'({2'b00, f}) < 8'(lim));
  endfunction

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == vist_pkg::S_IDLE);
  assign fire = (state_q == vist_pkg::S_SUM) && (!out_valid_q || out_o.ready);

  vist_ram #(.Width(vist_pkg::TimeW), .Depth(NUM_VREGS)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (fire && dst_ok_q),
    .waddr_i (dst_q[RegAw-1:0]),
    .wdata_i (finish_q),
    .re_i    (accept),
    .raddr_i (in_i.src_a_reg[RegAw-1:0]),
    .rdata_o (ram_a)
  );

  vist_ram #(.Width(vist_pkg::TimeW), .Depth(NUM_VREGS)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (fire && dst_ok_q),
    .waddr_i (dst_q[RegAw-1:0]),
    .wdata_i (finish_q),
    .re_i    (accept),
    .raddr_i (in_i.src_b_reg[RegAw-1:0]),
    .rdata_o (ram_b)
  );

  always_comb begin
    rd_a    = (sa_ok_q && reg_vld_q[sa_q[RegAw-1:0]]) ? ram_a : '0;
    rd_b    = (sb_ok_q && reg_vld_q[sb_q[RegAw-1:0]]) ? ram_b : '0;
    unit_rt = unit_ok_q ? unit_rt_q[unit_q[UnitAw-1:0]] : '0;
    fin_sum  = {1'b0, start_q} + {{(vist_pkg::TimeW-vist_pkg::LatW+1){1'b0}}, lat_q};
    busy_sum = {1'b0, busy_q} + {1'b0, add_q};
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      vist_pkg::S_IDLE: if (accept) state_d = vist_pkg::S_READ;
      vist_pkg::S_READ: state_d = vist_pkg::S_MAX;
      vist_pkg::S_MAX:  state_d = vist_pkg::S_FIN;
      vist_pkg::S_FIN:  state_d = vist_pkg::S_BASE;
      vist_pkg::S_BASE: state_d = vist_pkg::S_DIF;
      vist_pkg::S_DIF:  state_d = vist_pkg::S_SUM;
      vist_pkg::S_SUM:  if (fire) state_d = vist_pkg::S_IDLE;
      default:          state_d = vist_pkg::S_IDLE;
    endcase
  end

  // Datapath, one step per state
  always_ff @(posedge clk_i) begin
    if (accept) begin
      unit_q    <= in_i.unit_index;
      dst_q     <= in_i.dest_reg;
      sa_q      <= in_i.src_a_reg;
      sb_q      <= in_i.src_b_reg;
      unit_ok_q <= !in_i.unit_index[vist_pkg::UnitW-1] &&
                   (5'({2'b00, in_i.unit_index}) < 5'(NUM_UNITS));
      dst_ok_q  <= idx_ok(in_i.dest_reg, NUM_VREGS);
      sa_ok_q   <= idx_ok(in_i.src_a_reg, NUM_VREGS);
      sb_ok_q   <= idx_ok(in_i.src_b_reg, NUM_VREGS);
      lat_q     <= in_i.op_latency;
      issue_q   <= in_i.issue_time;
    end
    if (state_q == vist_pkg::S_READ) begin
      m1_q <= (unit_rt > issue_q) ? unit_rt : issue_q;
      m2_q <= (rd_b > rd_a) ? rd_b : rd_a;
    end
    if (state_q == vist_pkg::S_MAX) begin
      start_q <= (m2_q > m1_q) ? m2_q : m1_q;
    end
    if (state_q == vist_pkg::S_FIN) begin
      finish_q <= fin_sum[vist_pkg::TimeW] ? vist_pkg::TimeMax
                                           : fin_sum[vist_pkg::TimeW-1:0];
    end
    if (state_q == vist_pkg::S_BASE) begin
      none_q <= (last_q >= finish_q);
      base_q <= (last_q >= start_q) ? last_q : start_q;
    end
    if (state_q == vist_pkg::S_DIF) begin
      add_q <= none_q ? '0 : (finish_q - base_q);
    end
    if (fire) begin
      out_stall_q  <= start_q - issue_q;
      out_start_q  <= start_q;
      out_finish_q <= finish_q;
      out_total_q  <= busy_sum[vist_pkg::TimeW] ? vist_pkg::TimeMax
                                                : busy_sum[vist_pkg::TimeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vist_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      reg_vld_q   <= '0;
      last_q      <= '0;
      busy_q      <= '0;
      for (int i = 0; i < int'(NUM_UNITS); i++) begin
        unit_rt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (fire) begin
        last_q <= finish_q;
        busy_q <= busy_sum[vist_pkg::TimeW] ? vist_pkg::TimeMax
                                            : busy_sum[vist_pkg::TimeW-1:0];
        if (dst_ok_q) begin
          reg_vld_q[dst_q[RegAw-1:0]] <= 1'b1;
        end
        if (unit_ok_q) begin
          unit_rt_q[unit_q[UnitAw-1:0]] <= finish_q;
        end
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.stall_delay   = out_stall_q;
  assign out_o.start_time    = out_start_q;
  assign out_o.finish_time   = out_finish_q;
  assign out_o.total_runtime = out_total_q;

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == vist_pkg::S_READ)
    else $error("transfer did not start the read step");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vist_pkg::S_SUM) && out_valid_q && !out_o.ready
    |=> state_q == vist_pkg::S_SUM)
    else $error("write-back passed a waiting result");

  a_finish_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vist_pkg::S_DIF) |-> finish_q >= start_q)
    else $error("finish before start");

  a_busy_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> busy_q >= $past(busy_q))
    else $error("runtime total decreased");

  a_stall_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_start_q >= out_stall_q)
    else $error("stall exceeds start time");

endmodule

/* rtl/core/vist_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vist_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
